/* rtl/hdfi_pkg.sv */
package hdfi_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int FADE_PERIOD = 64;

  localparam int ADDR_W    = $clog2(MAX_PIXELS);
  localparam int BOUND_W   = ADDR_W + 1;
  localparam int FC_W      = $clog2(FADE_PERIOD);
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 16;
  localparam int LEVEL_W   = 8;
  localparam int WH_W      = 2 * DIM_W;
  localparam int YPROD_W   = COORD_W + DIM_W;
  localparam int POS_W     = YPROD_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 8'hFF;
  localparam logic [LEVEL_W-1:0] HIT_STEP    = 8'h10;
  localparam logic [FC_W-1:0]    FC_LAST     = FC_W'(FADE_PERIOD - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd256;

  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_SWEEP
  } state_t;

  // Address stage result, available in the cycle after accept.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic              in_img;
    logic              fade;
    logic [ADDR_W-1:0] addr;
  } idx_req_t;

  // Sequencer controls toward the memory and the input handshake.
  typedef struct packed {
    logic              busy;
    logic              accept;
    logic              fade_go;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic              wfill;
    logic [ADDR_W-1:0] waddr;
  } seq_ctl_t;

endpackage

/* rtl/hdfi_pixel_ram.sv */
module hdfi_pixel_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [hdfi_pkg::ADDR_W-1:0]   waddr,
  input  logic [hdfi_pkg::LEVEL_W-1:0]  wdata,
  input  logic                          re,
  input  logic [hdfi_pkg::ADDR_W-1:0]   raddr,
  output logic [hdfi_pkg::LEVEL_W-1:0]  rdata
);
  import hdfi_pkg::*;

  logic [LEVEL_W-1:0] mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hdfi_index.sv */
module hdfi_index (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hdfi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdfi_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            accept,
  input  logic                            fade_go,
  input  logic [1:0]                      kind,
  input  logic [hdfi_pkg::COORD_W-1:0]    x_coord,
  input  logic [hdfi_pkg::COORD_W-1:0]    y_coord,
  output logic [hdfi_pkg::BOUND_W-1:0]    bound,
  output hdfi_pkg::idx_req_t              req
);
  import hdfi_pkg::*;

  logic [DIM_W-1:0]   width_r, height_r;
  logic [BOUND_W-1:0] bound_r, bound_nxt;
  logic [WH_W-1:0]    area;

  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic               s1_fade_r;
  logic [COORD_W-1:0] s1_x_r;
  logic [YPROD_W-1:0] s1_yprod_r;
  logic [POS_W-1:0]   pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Image bound, capped at the memory depth.
  assign area = WH_W'(width_r * height_r);

  always_comb begin
    if (area > WH_W'(MAX_PIXELS)) begin
      bound_nxt = BOUND_W'(MAX_PIXELS);
    end else begin
      bound_nxt = BOUND_W'(area);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= BOUND_W'(MAX_PIXELS);
    end else begin
      bound_r <= bound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= kind_t'(kind);
      s1_fade_r  <= fade_go;
      s1_x_r     <= x_coord;
      s1_yprod_r <= YPROD_W'(y_coord * width_r);
    end
  end

  assign pos = POS_W'(s1_x_r) + POS_W'(s1_yprod_r);

  assign bound       = bound_r;
  assign req.valid   = s1_valid_r;
  assign req.kind    = s1_kind_r;
  assign req.fade    = s1_fade_r;
  assign req.in_img  = pos < POS_W'(bound_r);
  assign req.addr    = pos[ADDR_W-1:0];

endmodule

/* rtl/hdfi_seq.sv */
module hdfi_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    kind,
  input  logic                          pipe_active,
  input  logic [hdfi_pkg::BOUND_W-1:0]  bound,
  output hdfi_pkg::seq_ctl_t            ctl
);
  import hdfi_pkg::*;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [BOUND_W-1:0] sw_addr_r, sw_addr_nxt;
  logic               sw_wv_r;
  logic [ADDR_W-1:0]  sw_waddr_r;
  logic [FC_W-1:0]    fc_r;
  logic               sweep_more;

  assign sweep_more = sw_addr_r < bound;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == {ADDR_W{1'b1}}) state_nxt = ST_RUN;
      ST_RUN:   if (ctl.fade_go) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!pipe_active) state_nxt = ST_SWEEP;
      ST_SWEEP: if (!sweep_more) state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl.busy    = (state_r != ST_RUN);
    ctl.accept  = start && (state_r == ST_RUN);
    ctl.fade_go = ctl.accept && (kind_t'(kind) == KIND_FRAME) && (fc_r == FC_LAST);
    ctl.re      = (state_r == ST_SWEEP) && sweep_more;
    ctl.raddr   = sw_addr_r[ADDR_W-1:0];
    ctl.wfill   = (state_r == ST_CLEAR);
    ctl.we      = (state_r == ST_CLEAR) || sw_wv_r;
    ctl.waddr   = (state_r == ST_CLEAR) ? clr_addr_r : sw_waddr_r;
  end

  always_comb begin
    sw_addr_nxt = sw_addr_r;
    if (state_r == ST_DRAIN) begin
      sw_addr_nxt = '0;
    end else if (ctl.re) begin
      sw_addr_nxt = sw_addr_r + BOUND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      sw_addr_r  <= '0;
      sw_wv_r    <= 1'b0;
      fc_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      sw_addr_r <= sw_addr_nxt;
      sw_wv_r   <= ctl.re;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (ctl.accept && (kind_t'(kind) == KIND_FRAME)) begin
        fc_r <= (fc_r == FC_LAST) ? '0 : fc_r + FC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_waddr_r <= ctl.raddr;
  end

`ifndef SYNTH
  a_sweep_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !pipe_active)
    else $error("sweep running while items are in flight");

  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.re && sw_wv_r) |-> (ctl.raddr != sw_waddr_r))
    else $error("sweep read and write on one entry");

  a_fade_enters_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fade_go |=> (state_r == ST_DRAIN))
    else $error("fading frame end did not hold the input");
`endif

endmodule

/* rtl/hit_density_fade_image.sv */
// Pipeline: an accepted word passes the address stage and then the read stage, which
//   strobes out_valid. The receiver cannot stall, so a result word never waits.
// Throughput: one word per cycle for hits, reads and plain frame ends while busy is low;
//   a fading frame end holds busy while the stages drain and the image pixels are swept.
// Reset: synchronous, active low; a clearing pass then writes white to all 65536
//   entries, one per cycle, with busy high. Configuration writes are taken throughout.
module hit_density_fade_image (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [hdfi_pkg::COORD_W-1:0]    in_x_coord,
  input  logic [hdfi_pkg::COORD_W-1:0]    in_y_coord,
  output logic                            out_valid,
  output logic [hdfi_pkg::LEVEL_W-1:0]    out_level,
  output logic                            out_in_range,
  output logic                            out_faded,
  input  logic                            cfg_we,
  input  logic [hdfi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdfi_pkg::DIM_W-1:0]      cfg_data
);
  import hdfi_pkg::*;

  seq_ctl_t           ctl;
  idx_req_t           req;
  logic [BOUND_W-1:0] bound;
  logic               pipe_active;

  // Read stage registers: the memory word lands alongside these.
  logic               s3_valid_r;
  kind_t              s3_kind_r;
  logic               s3_inside_r;
  logic               s3_fade_r;
  logic [ADDR_W-1:0]  s3_addr_r;

  // Last memory write, for read-during-write forwarding.
  logic               lw_valid_r;
  logic [ADDR_W-1:0]  lw_addr_r;
  logic [LEVEL_W-1:0] lw_data_r;

  logic               ram_re, ram_we;
  logic [ADDR_W-1:0]  ram_raddr, ram_waddr;
  logic [LEVEL_W-1:0] ram_rdata, ram_wdata;

  logic               req_touch;
  logic               s3_touch;
  logic               hit_we;
  logic [LEVEL_W-1:0] cur_level;
  logic [LEVEL_W-1:0] hit_level;
  logic [LEVEL_W-1:0] fade_level;

  hdfi_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .kind        (in_kind),
    .pipe_active (pipe_active),
    .bound       (bound),
    .ctl         (ctl)
  );

  hdfi_index u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (ctl.accept),
    .fade_go   (ctl.fade_go),
    .kind      (in_kind),
    .x_coord   (in_x_coord),
    .y_coord   (in_y_coord),
    .bound     (bound),
    .req       (req)
  );

  assign busy        = ctl.busy;
  assign pipe_active = req.valid || s3_valid_r;

  // Hits and reads inside the image fetch their pixel; the sweep owns the port otherwise.
  assign req_touch = req.valid && req.in_img &&
                     ((req.kind == KIND_HIT) || (req.kind == KIND_READ));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_kind_r   <= req.kind;
    s3_inside_r <= req.in_img;
    s3_fade_r   <= req.fade;
    s3_addr_r   <= req.addr;
  end

  // Take the word just written when it hit the same pixel the cycle we read it.
  assign cur_level = (lw_valid_r && (lw_addr_r == s3_addr_r)) ? lw_data_r : ram_rdata;

  assign hit_level  = (cur_level >= HIT_STEP) ? (cur_level - HIT_STEP) : cur_level;
  assign fade_level = (ram_rdata == LEVEL_WHITE) ? ram_rdata : (ram_rdata + LEVEL_W'(1));

  assign s3_touch = s3_valid_r && s3_inside_r &&
                    ((s3_kind_r == KIND_HIT) || (s3_kind_r == KIND_READ));
  assign hit_we   = s3_touch && (s3_kind_r == KIND_HIT);

  // Memory port steering: clear and sweep never run while items are in flight.
  always_comb begin
    ram_re    = ctl.re || req_touch;
    ram_raddr = ctl.re ? ctl.raddr : req.addr;
    ram_we    = ctl.we || hit_we;
    ram_waddr = ctl.we ? ctl.waddr : s3_addr_r;
    if (ctl.we) begin
      ram_wdata = ctl.wfill ? LEVEL_WHITE : fade_level;
    end else begin
      ram_wdata = hit_level;
    end
  end

  hdfi_pixel_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else begin
      lw_valid_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= ram_waddr;
    lw_data_r <= ram_wdata;
  end

  // Result word: level and range only for hits and reads, fade flag only for frame ends.
  always_comb begin
    out_valid    = s3_valid_r;
    out_in_range = s3_touch;
    out_faded    = s3_valid_r && (s3_kind_r == KIND_FRAME) && s3_fade_r;
    out_level    = '0;
    if (s3_touch) begin
      out_level = (s3_kind_r == KIND_HIT) ? hit_level : cur_level;
    end
  end

`ifndef SYNTH
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.we && hit_we))
    else $error("hit write collides with clear or sweep write");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |=> ##1 out_valid)
    else $error("result word missing two cycles after accept");

  a_no_read_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.re && req_touch))
    else $error("sweep read collides with item read");
`endif

endmodule
